/* rtl/lvsc_pkg.sv */
// Shared types, constants and key rounding for the LRU view slot cache.
package lvsc_pkg;

   localparam int DEF_ENTRIES = 8;
   localparam int REQ_W       = 8;
   localparam int COORD_W     = 19;
   localparam int KEY_W       = 16;
   localparam int STAMP_W     = 64;
   localparam int SLOT_W      = 3;

   typedef struct packed {
      logic [REQ_W-1:0] requester;
      logic [KEY_W-1:0] key_x;
      logic [KEY_W-1:0] key_y;
   } probe_type;

   typedef struct packed {
      logic               found;
      logic               has_min;
      logic [STAMP_W-1:0] min_stamp;
      logic [REQ_W-1:0]   min_req;
   } token_type;

   typedef struct packed {
      logic               en;
      logic               fill;
      logic [REQ_W-1:0]   requester;
      logic [KEY_W-1:0]   key_x;
      logic [KEY_W-1:0]   key_y;
      logic [STAMP_W-1:0] stamp;
   } update_type;

   // round half away from zero from 1/16 pixel to whole pixels
   function automatic logic [KEY_W-1:0] round_key(input logic [COORD_W-1:0] coord);
      logic             neg;
      logic [COORD_W:0] mag;
      logic [COORD_W:0] sum;
      logic [KEY_W-1:0] r;
      neg = coord[COORD_W-1];
      mag = neg ? (~{1'b1, coord} + 1'b1) : {1'b0, coord};
      sum = mag + (COORD_W+1)'(8);
      r   = sum[KEY_W+3:4];
      return neg ? (~r + 1'b1) : r;
   endfunction

endpackage

/* rtl/lvsc_cell.sv */
// One table entry with its compare logic and the search token stage that follows it.
module lvsc_cell #(
   parameter int IDX_W    = 3,
   parameter int CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lvsc_pkg::probe_type    probe,
   input  lvsc_pkg::update_type   upd,
   input  logic [IDX_W-1:0]       upd_idx,
   input  logic                   in_valid,
   input  lvsc_pkg::token_type    tok_in,
   input  logic [IDX_W-1:0]       hit_idx_in,
   input  logic [IDX_W-1:0]       min_idx_in,
   input  logic                   keep,
   output logic                   out_valid,
   output lvsc_pkg::token_type    tok_out,
   output logic [IDX_W-1:0]       hit_idx_out,
   output logic [IDX_W-1:0]       min_idx_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                            valid_ff;
   logic [lvsc_pkg::REQ_W-1:0]      req_ff;
   logic [lvsc_pkg::KEY_W-1:0]      kx_ff;
   logic [lvsc_pkg::KEY_W-1:0]      ky_ff;
   logic [lvsc_pkg::STAMP_W-1:0]    stamp_ff;

   logic                            out_valid_ff;
   lvsc_pkg::token_type             tok_ff;
   lvsc_pkg::token_type             tok_in_nxt;
   logic [IDX_W-1:0]                hit_idx_ff;
   logic [IDX_W-1:0]                hit_idx_in_nxt;
   logic [IDX_W-1:0]                min_idx_ff;
   logic [IDX_W-1:0]                min_idx_in_nxt;

   logic match;
   logic take;

   assign match = valid_ff && (req_ff == probe.requester) &&
                  (kx_ff == probe.key_x) && (ky_ff == probe.key_y);
   assign take  = valid_ff && (!tok_in.has_min || (stamp_ff < tok_in.min_stamp));

   always_comb begin
      tok_in_nxt         = tok_in;
      tok_in_nxt.found   = tok_in.found | match;
      tok_in_nxt.has_min = tok_in.has_min | valid_ff;
      hit_idx_in_nxt     = tok_in.found ? hit_idx_in : MY_IDX;
      min_idx_in_nxt     = min_idx_in;
      if (take) begin
         tok_in_nxt.min_stamp = stamp_ff;
         tok_in_nxt.min_req   = req_ff;
         min_idx_in_nxt       = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid | (out_valid_ff & keep);
         if (upd.en && (upd_idx == MY_IDX)) begin
            if (upd.fill) begin
               valid_ff <= 1'b1;
               req_ff   <= upd.requester;
               kx_ff    <= upd.key_x;
               ky_ff    <= upd.key_y;
            end
            stamp_ff <= upd.stamp;
         end
      end
      if (in_valid) begin
         tok_ff     <= tok_in_nxt;
         hit_idx_ff <= hit_idx_in_nxt;
         min_idx_ff <= min_idx_in_nxt;
      end
   end

   assign out_valid   = out_valid_ff;
   assign tok_out     = tok_ff;
   assign hit_idx_out = hit_idx_ff;
   assign min_idx_out = min_idx_ff;

endmodule

/* rtl/lru_view_slot_cache.sv */
// Top level of the LRU view slot cache: request head, cell chain, commit and response register.
//
//   Channel | Ports                                              | Direction
//   req     | req_valid req_ready req_requester_id req_center_x/y | in
//   rsp     | rsp_valid rsp_ready rsp_hit rsp_slot rsp_evicted    | out
//           | rsp_evicted_same_requester                         |
//
// A request is registered at the head, then the search token walks the cell chain one cell
// per cycle, then the result commits and the table is updated.
// The next request is accepted in the commit cycle; none is taken while one is still in flight.
// Reset clears the valid bits, the use counter and the fill count.
// A stalled response holds the token at the chain end until the response register frees.
module lru_view_slot_cache #(
   parameter int ENTRIES = lvsc_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lvsc_pkg::REQ_W-1:0]          req_requester_id,
   input  logic signed [lvsc_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [lvsc_pkg::COORD_W-1:0] req_center_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [lvsc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                                rsp_evicted,
   output logic                                rsp_evicted_same_requester
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int WIDE_W = (IDX_W > lvsc_pkg::SLOT_W) ? IDX_W : lvsc_pkg::SLOT_W;

   logic                           busy_ff;
   logic                           head_v_ff;
   lvsc_pkg::probe_type            probe_ff;
   logic [lvsc_pkg::STAMP_W-1:0]   use_cnt_ff;
   logic [FILL_W-1:0]              fill_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_hit_ff;
   logic [lvsc_pkg::SLOT_W-1:0]    rsp_slot_ff;
   logic                           rsp_evicted_ff;
   logic                           rsp_same_ff;

   logic [ENTRIES:0]               tv;
   lvsc_pkg::token_type            tok   [ENTRIES+1];
   logic [IDX_W-1:0]               hidx  [ENTRIES+1];
   logic [IDX_W-1:0]               midx  [ENTRIES+1];

   logic                           accept;
   logic                           commit;
   logic                           full;
   logic                           found;
   logic                           evict;
   logic [IDX_W-1:0]               target;
   logic [WIDE_W-1:0]              target_wide;
   lvsc_pkg::update_type           upd;

   assign accept = req_valid && req_ready;
   assign commit = tv[ENTRIES] && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || commit;

   assign tv[0]   = head_v_ff;
   assign tok[0]  = '0;
   assign hidx[0] = '0;
   assign midx[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lvsc_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .probe       (probe_ff),
         .upd         (upd),
         .upd_idx     (target),
         .in_valid    (tv[i]),
         .tok_in      (tok[i]),
         .hit_idx_in  (hidx[i]),
         .min_idx_in  (midx[i]),
         .keep        ((i == ENTRIES - 1) ? !commit : 1'b0),
         .out_valid   (tv[i+1]),
         .tok_out     (tok[i+1]),
         .hit_idx_out (hidx[i+1]),
         .min_idx_out (midx[i+1])
      );
   end

   assign found  = tok[ENTRIES].found;
   assign full   = (fill_ff == FILL_W'(ENTRIES));
   assign evict  = !found && full;
   assign target = found ? hidx[ENTRIES] : (full ? midx[ENTRIES] : fill_ff[IDX_W-1:0]);
   assign target_wide = WIDE_W'(target);

   always_comb begin
      upd.en        = commit;
      upd.fill      = !found;
      upd.requester = probe_ff.requester;
      upd.key_x     = probe_ff.key_x;
      upd.key_y     = probe_ff.key_y;
      upd.stamp     = use_cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         head_v_ff    <= 1'b0;
         use_cnt_ff   <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_v_ff <= accept;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (commit) begin
            busy_ff <= 1'b0;
         end
         if (commit) begin
            use_cnt_ff   <= use_cnt_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
            if (!found && !full) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         probe_ff.requester <= req_requester_id;
         probe_ff.key_x     <= lvsc_pkg::round_key(req_center_x);
         probe_ff.key_y     <= lvsc_pkg::round_key(req_center_y);
      end
      if (commit) begin
         rsp_hit_ff     <= found;
         rsp_slot_ff    <= target_wide[lvsc_pkg::SLOT_W-1:0];
         rsp_evicted_ff <= evict;
         rsp_same_ff    <= evict && (tok[ENTRIES].min_req == probe_ff.requester);
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_hit                    = rsp_hit_ff;
   assign rsp_slot                   = rsp_slot_ff;
   assign rsp_evicted                = rsp_evicted_ff;
   assign rsp_evicted_same_requester = rsp_same_ff;

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tv))
      else $error("more than one search token in the chain");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      tv[ENTRIES] |-> busy_ff)
      else $error("token at chain end while idle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ENTRIES))
      else $error("fill count past table size");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (commit && found) |=> (rsp_hit && !rsp_evicted && !rsp_evicted_same_requester))
      else $error("hit reported an eviction");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the LRU view slot cache against a behavioral table.
module tb;

   localparam int NUM_SLOTS   = lvsc_pkg::DEF_ENTRIES;
   localparam int REQ_W       = lvsc_pkg::REQ_W;
   localparam int COORD_W     = lvsc_pkg::COORD_W;
   localparam int KEY_W       = lvsc_pkg::KEY_W;
   localparam int STAMP_W     = lvsc_pkg::STAMP_W;
   localparam int SLOT_W      = lvsc_pkg::SLOT_W;
   localparam int RANDOM_REQS = 1030;
   localparam int POOL_SIZE   = 12;
   localparam int IDLE_PCT    = 18;

   typedef struct {
      logic [REQ_W-1:0]          id;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      bit                        drain_first;
   } view_req_type;

   typedef struct {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              evicted;
      logic              evicted_same;
   } slot_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [REQ_W-1:0]          req_requester_id = '0;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_hit;
   logic [SLOT_W-1:0]         rsp_slot;
   logic                      rsp_evicted;
   logic                      rsp_evicted_same_requester;

   view_req_type    view_reqs[$];
   slot_result_type predicted_slots[$];
   view_req_type    cur_req;
   int              pending = 0;
   int              cycle_no = 0;
   int              errors = 0;
   logic            calm;

   logic              tag_valid[NUM_SLOTS];
   logic [REQ_W-1:0]  tag_req[NUM_SLOTS];
   logic [KEY_W-1:0]  tag_kx[NUM_SLOTS];
   logic [KEY_W-1:0]  tag_ky[NUM_SLOTS];
   logic [STAMP_W-1:0] tag_stamp[NUM_SLOTS];
   logic [STAMP_W-1:0] use_clock = '0;
   int                filled = 0;

   int pool_id[POOL_SIZE];
   int pool_kx[POOL_SIZE];
   int pool_ky[POOL_SIZE];

   lru_view_slot_cache u_top (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_requester_id           (req_requester_id),
      .req_center_x               (req_center_x),
      .req_center_y               (req_center_y),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_hit                    (rsp_hit),
      .rsp_slot                   (rsp_slot),
      .rsp_evicted                (rsp_evicted),
      .rsp_evicted_same_requester (rsp_evicted_same_requester)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   assign calm = (cycle_no >= 4000) && (cycle_no < 6500);

   function automatic logic [KEY_W-1:0] pixel_key(
      input logic signed [COORD_W-1:0] c);
      int v;
      int mag;
      int r;
      v   = c;
      mag = (v < 0) ? -v : v;
      r   = (mag + 8) >> 4;
      return (v < 0) ? KEY_W'(-r) : KEY_W'(r);
   endfunction

   function automatic slot_result_type lookup_view(input view_req_type rq);
      logic [KEY_W-1:0] kx;
      logic [KEY_W-1:0] ky;
      int               match;
      int               victim;
      slot_result_type  res;
      kx    = pixel_key(rq.cx);
      ky    = pixel_key(rq.cy);
      match = -1;
      res   = '{default: '0};
      for (int i = 0; i < NUM_SLOTS; i++)
         if (match < 0 && tag_valid[i] && tag_req[i] == rq.id &&
             tag_kx[i] == kx && tag_ky[i] == ky)
            match = i;
      use_clock = use_clock + 1'b1;
      if (match >= 0) begin
         tag_stamp[match] = use_clock;
         res.hit  = 1'b1;
         res.slot = SLOT_W'(match);
      end else begin
         if (filled < NUM_SLOTS) begin
            victim = filled;
            filled++;
         end else begin
            victim = 0;
            for (int i = 1; i < NUM_SLOTS; i++)
               if (tag_stamp[i] < tag_stamp[victim])
                  victim = i;
            res.evicted      = 1'b1;
            res.evicted_same = tag_valid[victim] && tag_req[victim] == rq.id;
         end
         tag_valid[victim] = 1'b1;
         tag_req[victim]   = rq.id;
         tag_kx[victim]    = kx;
         tag_ky[victim]    = ky;
         tag_stamp[victim] = use_clock;
         res.slot          = SLOT_W'(victim);
      end
      return res;
   endfunction

   task automatic add_req(input int id, input int cx, input int cy, input bit drain);
      view_req_type rq;
      rq.id          = REQ_W'(id);
      rq.cx          = COORD_W'(cx);
      rq.cy          = COORD_W'(cy);
      rq.drain_first = drain;
      view_reqs.insert(view_reqs.size(), rq);
   endtask

   function automatic int coord_near(input int k);
      return k * 16 + int'($urandom_range(14)) - 7;
   endfunction

   task automatic refill_pool(input int p);
      pool_id[p] = ($urandom_range(3) == 0) ? int'($urandom_range(255)) :
                                              int'($urandom_range(3));
      pool_kx[p] = int'($urandom_range(32766)) - 16383;
      pool_ky[p] = int'($urandom_range(32766)) - 16383;
   endtask

   always @(posedge clock) begin
      if (reset)
         cycle_no <= 0;
      else
         cycle_no <= cycle_no + 1;
   end

   always @(posedge clock) begin
      if (reset)
         pending <= 0;
      else
         pending <= pending + int'(req_valid && req_ready) - int'(rsp_valid && rsp_ready);
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predicted_slots.insert(predicted_slots.size(), lookup_view(cur_req));
         if (!req_valid || req_ready) begin
            if (view_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
                (!view_reqs[0].drain_first || (pending == 0 && !(req_valid && req_ready)))) begin
               cur_req = view_reqs.pop_front();
               req_valid        <= 1'b1;
               req_requester_id <= cur_req.id;
               req_center_x     <= cur_req.cx;
               req_center_y     <= cur_req.cy;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_slots.size() == 0) begin
               $error("unexpected transaction: hit %0d slot %0d", rsp_hit, rsp_slot);
               errors++;
            end else begin
               want = predicted_slots.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("rsp_hit: expected %0d, actual %0d", want.hit, rsp_hit);
                  errors++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("rsp_slot: expected %0d, actual %0d", want.slot, rsp_slot);
                  errors++;
               end
               if (rsp_evicted !== want.evicted) begin
                  $error("rsp_evicted: expected %0d, actual %0d", want.evicted, rsp_evicted);
                  errors++;
               end
               if (rsp_evicted_same_requester !== want.evicted_same) begin
                  $error("rsp_evicted_same_requester: expected %0d, actual %0d",
                         want.evicted_same, rsp_evicted_same_requester);
                  errors++;
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      int r;
      int p;
      for (int i = 0; i < NUM_SLOTS; i++)
         tag_valid[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++)
         refill_pool(i);

      add_req(0, 0, 0, 0);
      add_req(0, 7, -7, 0);
      add_req(0, 8, 0, 0);
      add_req(0, -8, 0, 0);
      add_req(0, -7, 0, 0);
      add_req(255, 262143, -262144, 0);
      add_req(255, 262136, -262136, 0);
      add_req(255, -262144, 262143, 0);
      add_req(1, 0, 0, 0);
      add_req(128, 24, -24, 0);
      add_req(127, 23, -23, 0);
      add_req(0, 0, 0, 0);
      add_req(2, 100, 100, 1);
      add_req(0, 9999, 5, 0);
      add_req(0, -9, 9, 0);
      add_req(170, -1, 1, 0);
      add_req(85, -262143, 262135, 0);
      add_req(255, 262140, -262140, 0);
      add_req(2, 104, 92, 0);
      add_req(128, 25, -25, 0);
      add_req(0, -24, 40, 1);
      add_req(85, -262136, 262130, 0);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         r = $urandom_range(99);
         p = $urandom_range(POOL_SIZE - 1);
         if (r < 62) begin
            add_req(pool_id[p], coord_near(pool_kx[p]), coord_near(pool_ky[p]), n % 250 == 249);
         end else if (r < 70) begin
            refill_pool(p);
            add_req(pool_id[p], coord_near(pool_kx[p]), coord_near(pool_ky[p]), n % 250 == 249);
         end else if (r < 75) begin
            add_req(pool_id[p] ^ 1, coord_near(pool_kx[p]), coord_near(pool_ky[p]),
                    n % 250 == 249);
         end else begin
            add_req($urandom_range(255), int'($urandom()), int'($urandom()), n % 250 == 249);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (view_reqs.size() != 0 || req_valid || pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (predicted_slots.size() != 0) begin
         $error("%0d predicted transactions never arrived", predicted_slots.size());
         errors++;
      end
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
